// ===== hw/rtl/md5d_pkg.sv =====
// md5d_pkg: types, constants and round helper functions of the md5 digest unit
// standalone package, used by every module of the md5 digest unit
`default_nettype none

package md5d_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] quad_t;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic load;
    logic step;
  } core_ctl_t;

  // initial chaining words, word 0 (A) in the low slot
  localparam quad_t CHAIN_IV = {32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [3:0] IDX_LEN_LO = 4'd14;
  localparam logic [3:0] IDX_LAST   = 4'd15;
  localparam logic [5:0] RND_LAST   = 6'd63;

  localparam word_t ROUND_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  // block buffer slot read by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    unique case (rnd[5:4])
      2'd0: g = r;
      2'd1: g = 4'((r << 2) + r + 4'd1);
      2'd2: g = 4'((r << 1) + r + 4'd5);
      default: g = 4'((r << 3) - r);
    endcase
    return g;
  endfunction

  // left rotate amount of a round
  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    unique case ({rnd[5:4], rnd[1:0]})
      4'h0: s = 5'd7;
      4'h1: s = 5'd12;
      4'h2: s = 5'd17;
      4'h3: s = 5'd22;
      4'h4: s = 5'd5;
      4'h5: s = 5'd9;
      4'h6: s = 5'd14;
      4'h7: s = 5'd20;
      4'h8: s = 5'd4;
      4'h9: s = 5'd11;
      4'hA: s = 5'd16;
      4'hB: s = 5'd23;
      4'hC: s = 5'd6;
      4'hD: s = 5'd10;
      4'hE: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/md5d_msg_ram.sv =====
// md5d_msg_ram: 16 x 32 block buffer, one write port, one registered read port
// depends on md5d_pkg
`default_nettype none

module md5d_msg_ram
  import md5d_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  logic [3:0] wr_addr,
  input  word_t      wr_data,
  input  logic [3:0] rd_addr,
  output word_t      rd_data
);

  word_t mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/md5d_core.sv =====
// md5d_core: md5 round unit, one round per cycle while ctl.step is set, on the working words a..d
// depends on md5d_pkg; message words come from md5d_msg_ram
`default_nettype none

module md5d_core
  import md5d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  core_ctl_t  ctl,
  input  quad_t      chain,
  input  word_t      rd_data,
  output logic [3:0] rd_addr,
  output quad_t      work,
  output logic       last_round
);

  logic [5:0] rnd;
  word_t      a, b, c, d;
  word_t      f;
  word_t      sum;
  word_t      nb;

  assign a = work[0];
  assign b = work[1];
  assign c = work[2];
  assign d = work[3];

  always_comb begin
    unique case (rnd[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum = a + f + ROUND_K[rnd] + rd_data;
    nb  = b + rotl(sum, rot_amount(rnd));
  end

  // address of the word for the next round, read ahead through the registered buffer port
  assign rd_addr    = msg_index(ctl.load ? 6'd0 : rnd + 6'd1);
  assign last_round = (rnd == RND_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (ctl.load) begin
      rnd <= '0;
    end else if (ctl.step) begin
      rnd <= rnd + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work <= chain;
    end else if (ctl.step) begin
      work <= {c, b, nb, d};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/md5_digest_unit.sv =====
// md5_digest_unit: top level of the md5 digest unit, message sequencer and padding
// depends on md5d_pkg, md5d_msg_ram, md5d_core
`default_nettype none

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: data_word, valid_bytes; tlast: last_word
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: digest_word0..digest_word3
//
// a non-final word is written straight into the block buffer; the sixteenth word of a
// block starts a compression (one read setup, 64 rounds through the single
// round unit fed by the buffer read port, one chaining add)
// the final word adds the padding words, one or two compressions and the load
// of the digest register
// rst is synchronous and resets the sequencer, chaining words, counts and
// output valid; the buffer itself is never cleared, every slot is written
// before a compression reads it
// a waiting digest does not stop input; only a new digest waits for the
// output register to free up

module md5_digest_unit
  import md5d_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // [31:0] data_word, [34:32] valid_bytes, zero fill
  input  logic         s_axis_tlast,   // last_word
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // [31:0] word0 .. [127:96] word3
);

  state_t     state, state_next;
  quad_t      chain;
  logic [3:0] idx;
  logic [63:0] bit_count;

  // padding progress of the current message
  logic       in_pad;     // message words done, writing padding
  logic       pend80;     // pad byte still owed as a word of its own
  logic       lo_done;    // low length word written
  logic       fin;        // high length word written, last compression running

  core_ctl_t  core_ctl;
  logic [3:0] rd_addr;
  word_t      rd_data;
  quad_t      work;
  logic       last_round;

  logic       wr_en;
  word_t      wr_data;
  word_t      in_word;
  word_t      pad_word;
  logic       s_xfer;
  logic       out_free;
  word_t      data_word;
  logic [2:0] valid_bytes;
  logic [2:0] vb_eff;
  logic       full_last;

  assign data_word   = s_axis_tdata[31:0];
  assign valid_bytes = s_axis_tdata[34:32];
  assign s_xfer      = s_axis_tvalid && s_axis_tready;
  assign out_free    = !m_axis_tvalid || m_axis_tready;

  // byte count of the word: only a final word may be short, above four means four
  assign vb_eff    = (s_axis_tlast && valid_bytes <= 3'd4) ? valid_bytes : 3'd4;
  assign full_last = s_axis_tlast && (vb_eff == 3'd4);

  // short final word: clear unused bytes, pad byte in the first free lane
  always_comb begin
    if (s_axis_tlast && vb_eff != 3'd4) begin
      unique case (vb_eff[1:0])
        2'd0: in_word = {24'h0, PAD_BYTE};
        2'd1: in_word = {16'h0, PAD_BYTE, data_word[7:0]};
        2'd2: in_word = {8'h0, PAD_BYTE, data_word[15:0]};
        default: in_word = {PAD_BYTE, data_word[23:0]};
      endcase
    end else begin
      in_word = data_word;
    end
  end

  // padding words: pad byte if owed, zeros, then length low and high
  always_comb begin
    if (pend80) begin
      pad_word = {24'h0, PAD_BYTE};
    end else if (lo_done) begin
      pad_word = bit_count[63:32];
    end else if (idx == IDX_LEN_LO) begin
      pad_word = bit_count[31:0];
    end else begin
      pad_word = '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          if (idx == IDX_LAST) begin
            state_next = ST_LOAD;
          end else if (s_axis_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (idx == IDX_LAST) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (last_round) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        priority if (fin) begin
          state_next = ST_OUT;
        end else if (in_pad) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    core_ctl      = '0;
    wr_en         = 1'b0;
    wr_data       = in_word;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        wr_en         = s_axis_tvalid;
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_data = pad_word;
      end
      ST_LOAD:  core_ctl.load = 1'b1;
      ST_ROUND: core_ctl.step = 1'b1;
      ST_FOLD, ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // message state: chaining words, slot index, length and padding flags
  always_ff @(posedge clk) begin
    if (rst) begin
      chain     <= CHAIN_IV;
      idx       <= '0;
      bit_count <= '0;
      in_pad    <= 1'b0;
      pend80    <= 1'b0;
      lo_done   <= 1'b0;
      fin       <= 1'b0;
    end else begin
      if (wr_en) begin
        idx <= idx + 4'd1;
      end
      if (state == ST_IDLE && s_xfer) begin
        bit_count <= bit_count + {58'h0, vb_eff, 3'b000};
        in_pad    <= s_axis_tlast;
        pend80    <= full_last;
      end
      if (state == ST_PAD) begin
        pend80 <= 1'b0;
        if (!pend80 && !lo_done && idx == IDX_LEN_LO) begin
          lo_done <= 1'b1;
        end
        if (!pend80 && lo_done) begin
          fin <= 1'b1;
        end
      end
      if (state == ST_FOLD) begin
        chain[0] <= chain[0] + work[0];
        chain[1] <= chain[1] + work[1];
        chain[2] <= chain[2] + work[2];
        chain[3] <= chain[3] + work[3];
      end
      if (state == ST_OUT && out_free) begin
        chain     <= CHAIN_IV;
        idx       <= '0;
        bit_count <= '0;
        in_pad    <= 1'b0;
        pend80    <= 1'b0;
        lo_done   <= 1'b0;
        fin       <= 1'b0;
      end
    end
  end

  // digest output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_axis_tdata <= chain;
    end
  end

  // every slot is written before the first read of a compression samples the buffer,
  // so the buffer needs no bypass
  md5d_msg_ram u_msg_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  md5d_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctl        (core_ctl),
    .chain      (chain),
    .rd_data    (rd_data),
    .rd_addr    (rd_addr),
    .work       (work),
    .last_round (last_round)
  );

endmodule

`default_nettype wire
